@@ rtl/mrtu_pkg.sv @@
// Shared types, codes and the CRC-16 byte step of the Modbus RTU slave frame handler.
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int REG_COUNT_DEF   = 256;
    localparam int MAX_RESP        = 64;

    localparam logic [7:0] FN_READ   = 8'h03;
    localparam logic [7:0] FN_WRITE1 = 8'h06;
    localparam logic [7:0] FN_WRITEN = 8'h10;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_LWR   = 2'd1;
    localparam logic [1:0] KIND_LRD   = 2'd2;

    localparam logic [1:0] CFG_STATION = 2'd0;
    localparam logic [1:0] CFG_BASE    = 2'd1;
    localparam logic [1:0] CFG_COUNT   = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_LWR   = 2'd1,
        CMD_LRD   = 2'd2
    } cmd_kind_t;

    // One unit of work for the back end: a checked frame or a local access
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  fn;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [7:0]  b5;
        logic [15:0] off;
        logic [15:0] n;
        logic [7:0]  addr;
        logic [15:0] value;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] read_value;
        logic        data_changed;
    } out_t;

    typedef struct packed {
        logic clearing;
        logic frame_done;
    } bk_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mrtu_fifo.sv @@
// Two-entry register queue used between the front and back ends and at the result side.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_fifo
    import mrtu_pkg::*;
#(
    parameter int W = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr,
    input  wire logic [W-1:0] wdata,
    output logic              qfull,
    input  wire logic         rd,
    output logic [W-1:0]      rdata,
    output logic              qempty
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg, wp_next;
    logic         rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_wr, do_rd;

    assign qfull  = (cnt_reg == 2'd2);
    assign qempty = (cnt_reg == 2'd0);
    assign rdata  = mem_reg[rp_reg];
    assign do_wr  = wr & ~qfull;
    assign do_rd  = rd & ~qempty;

    always_comb
    begin
        wp_next  = wp_reg ^ do_wr;
        rp_next  = rp_reg ^ do_rd;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

`default_nettype wire

@@ rtl/mrtu_front.sv @@
// Front end: collects frame bytes and running CRC, classifies each transaction.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_front
    import mrtu_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF,
    localparam int FI_W = $clog2(FRAME_BYTES)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [1:0]      kind,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            frame_end,
    input  wire logic [7:0]      local_addr,
    input  wire logic [15:0]     local_value,
    input  wire logic [15:0]     window_base,
    input  wire logic [8:0]      window_count,
    output logic                 cmd_push,
    output cmd_t                 cmd_data,
    input  wire logic            cmd_full,
    input  wire bk_stat_t        bk_stat,
    input  wire logic [FI_W-1:0] fr_addr,
    output logic [7:0]           fr_data
);

    localparam int LEN_W = $clog2(FRAME_BYTES + 1);

    logic [7:0]       fmem [FRAME_BYTES];
    logic [7:0]       fr_data_reg;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic             closing_reg, closing_next;
    logic             pending_reg, pending_next;

    logic [7:0]       b1_reg, b2_reg, b3_reg, b4_reg, b5_reg;
    logic [15:0]      crct_reg;
    logic [7:0]       gotlo_reg, gothi_reg;

    logic             accept, is_byte, store;
    logic [15:0]      n16, a16, n_eff;
    logic [16:0]      off17;
    logic [17:0]      sum18, resp18, need18, len18, target18, pos18;
    logic             base_ok, rng_ok, size_ok, crc_ok, frame_ok;

    assign accept  = push & ~full;
    assign is_byte = accept && (kind == KIND_FRAME);
    assign store   = is_byte && (len_reg < LEN_W'(FRAME_BYTES));
    assign full    = closing_reg | pending_reg | cmd_full | bk_stat.clearing;
    assign fr_data = fr_data_reg;

    // Classify the closed frame from the captured header and CRC bytes
    always_comb
    begin
        n16      = {b4_reg, b5_reg};
        a16      = {b2_reg, b3_reg};
        n_eff    = (b1_reg == FN_WRITE1) ? 16'd1 : n16;
        base_ok  = (a16 >= window_base);
        off17    = {1'b0, a16} - {1'b0, window_base};
        sum18    = {1'b0, off17} + {2'b00, n_eff};
        rng_ok   = (n_eff != 16'd0) && base_ok && (sum18 <= {9'd0, window_count})
                   && (sum18 <= 18'(REG_COUNT));
        resp18   = 18'd5 + {1'b0, n16, 1'b0};
        size_ok  = (resp18 <= 18'(FRAME_BYTES)) && (resp18 <= 18'(MAX_RESP));
        need18   = 18'd9 + {1'b0, n16, 1'b0};
        len18    = 18'(len_reg);
        pos18    = 18'(len_reg);
        target18 = (b1_reg == FN_WRITEN) ? (18'd7 + {1'b0, n16, 1'b0}) : 18'd6;
        crc_ok   = (crct_reg == {gothi_reg, gotlo_reg});
        case (b1_reg)
            FN_READ:   frame_ok = (len18 >= 18'd8) && crc_ok && rng_ok && size_ok;
            FN_WRITE1: frame_ok = (len18 >= 18'd8) && crc_ok && rng_ok;
            FN_WRITEN: frame_ok = (len18 >= 18'd7) && rng_ok && (len18 >= need18) && crc_ok;
            default:   frame_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd_data       = '0;
        cmd_data.fn    = b1_reg;
        cmd_data.b2    = b2_reg;
        cmd_data.b3    = b3_reg;
        cmd_data.b4    = b4_reg;
        cmd_data.b5    = b5_reg;
        cmd_data.off   = off17[15:0];
        cmd_data.n     = n_eff;
        cmd_data.addr  = local_addr;
        cmd_data.value = local_value;
        if (closing_reg)
            cmd_data.kind = CMD_FRAME;
        else if (kind == KIND_LWR)
            cmd_data.kind = CMD_LWR;
        else
            cmd_data.kind = CMD_LRD;
        cmd_push = (closing_reg & frame_ok)
                   | (accept & ((kind == KIND_LWR) || (kind == KIND_LRD)));
    end

    always_comb
    begin
        len_next     = len_reg;
        crc_next     = crc_reg;
        closing_next = is_byte & frame_end;
        pending_next = pending_reg;
        if (store)
        begin
            len_next = len_reg + LEN_W'(1);
            crc_next = crc_byte(crc_reg, rx_byte);
        end
        if (closing_reg)
        begin
            len_next     = '0;
            crc_next     = CRC_INIT;
            pending_next = frame_ok;
        end
        else if (bk_stat.frame_done)
            pending_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            crc_reg     <= CRC_INIT;
            closing_reg <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            crc_reg     <= crc_next;
            closing_reg <= closing_next;
            pending_reg <= pending_next;
        end
    end

    // Capture header fields and the CRC at the position where the trailer starts
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            if (pos18 == 18'd1)
                b1_reg <= rx_byte;
            if (pos18 == 18'd2)
                b2_reg <= rx_byte;
            if (pos18 == 18'd3)
                b3_reg <= rx_byte;
            if (pos18 == 18'd4)
                b4_reg <= rx_byte;
            if (pos18 == 18'd5)
                b5_reg <= rx_byte;
            if (pos18 == target18)
            begin
                crct_reg  <= crc_reg;
                gotlo_reg <= rx_byte;
            end
            if (pos18 == target18 + 18'd1)
                gothi_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
            fmem[len_reg[FI_W-1:0]] <= rx_byte;
        fr_data_reg <= fmem[fr_addr];
    end

endmodule

`default_nettype wire

@@ rtl/mrtu_back.sv @@
// Back end: register store, write-back of requests and response byte sequencing.
`timescale 1ns / 1ps
`default_nettype none

module mrtu_back
    import mrtu_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF,
    localparam int FI_W = $clog2(FRAME_BYTES)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      station_id,
    input  wire logic            cmd_empty,
    output logic                 cmd_pop,
    input  wire cmd_t            cmd_data,
    input  wire logic            out_full,
    output logic                 out_push,
    output out_t                 out_data,
    output logic [FI_W-1:0]      fr_addr,
    input  wire logic [7:0]      fr_data,
    output bk_stat_t             bk_stat
);

    localparam int RI_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CL_W = $clog2(REG_COUNT + 1);
    localparam logic [2:0] HDR_LAST_RD = 3'd2;
    localparam logic [2:0] HDR_LAST_WR = 3'd5;

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_W10_A   = 13'b0000000000100,
        S_W10_B   = 13'b0000000001000,
        S_W10_C   = 13'b0000000010000,
        S_HDR     = 13'b0000000100000,
        S_RD_A    = 13'b0000001000000,
        S_RD_HI   = 13'b0000010000000,
        S_RD_LO   = 13'b0000100000000,
        S_CRC_LO  = 13'b0001000000000,
        S_CRC_HI  = 13'b0010000000000,
        S_LRD_OUT = 13'b0100000000000,
        S_SPARE   = 13'b1000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CL_W-1:0] clr_reg, clr_next;
    logic [15:0]     i_reg, i_next;
    logic [2:0]      h_reg, h_next;
    logic [15:0]     crc_reg, crc_next;
    cmd_t            cmd_reg, cmd_next;
    logic [7:0]      hi_reg, hi_next;
    logic            oor_reg, oor_next;

    logic [15:0]     rmem [REG_COUNT];
    logic [15:0]     rdata_reg;
    logic            we, re;
    logic [RI_W-1:0] waddr, raddr;
    logic [15:0]     wdata;

    logic [15:0]     sidx;
    logic [RI_W-1:0] ridx;
    logic [17:0]     fa18;
    logic            i_last;
    logic [7:0]      hdr_byte;
    logic            lcl_ok;

    always_comb
    begin
        sidx   = cmd_reg.off + i_reg;
        ridx   = sidx[RI_W-1:0];
        fa18   = 18'd7 + {1'b0, i_reg, 1'b0};
        i_last = ((17'(i_reg) + 17'd1) == 17'(cmd_reg.n));
        lcl_ok = (17'(cmd_data.addr) < 17'(REG_COUNT));
        case (h_reg)
            3'd0:    hdr_byte = station_id;
            3'd1:    hdr_byte = cmd_reg.fn;
            3'd2:    hdr_byte = (cmd_reg.fn == FN_READ) ? {cmd_reg.n[6:0], 1'b0} : cmd_reg.b2;
            3'd3:    hdr_byte = cmd_reg.b3;
            3'd4:    hdr_byte = cmd_reg.b4;
            default: hdr_byte = cmd_reg.b5;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        i_next     = i_reg;
        h_next     = h_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        hi_next    = hi_reg;
        oor_next   = oor_reg;
        cmd_pop    = 1'b0;
        out_push   = 1'b0;
        out_data   = '0;
        we         = 1'b0;
        waddr      = ridx;
        wdata      = 16'd0;
        re         = 1'b0;
        raddr      = ridx;
        fr_addr    = fa18[FI_W-1:0];
        bk_stat    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                bk_stat.clearing = 1'b1;
                we       = 1'b1;
                waddr    = clr_reg[RI_W-1:0];
                clr_next = clr_reg + CL_W'(1);
                if (clr_reg == CL_W'(REG_COUNT - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_data;
                    i_next   = 16'd0;
                    h_next   = 3'd0;
                    crc_next = CRC_INIT;
                    case (cmd_data.kind)
                        CMD_LWR:
                        begin
                            we    = lcl_ok;
                            waddr = RI_W'(cmd_data.addr);
                            wdata = cmd_data.value;
                        end
                        CMD_LRD:
                        begin
                            re         = 1'b1;
                            raddr      = RI_W'(cmd_data.addr);
                            oor_next   = ~lcl_ok;
                            state_next = S_LRD_OUT;
                        end
                        default:
                        begin
                            if (cmd_data.fn == FN_WRITE1)
                            begin
                                we    = 1'b1;
                                waddr = cmd_data.off[RI_W-1:0];
                                wdata = {cmd_data.b4, cmd_data.b5};
                                state_next = S_HDR;
                            end
                            else if (cmd_data.fn == FN_WRITEN)
                                state_next = S_W10_A;
                            else
                                state_next = S_HDR;
                        end
                    endcase
                end
            end
            S_W10_A:
            begin
                state_next = S_W10_B;
            end
            S_W10_B:
            begin
                // High byte is out of the frame store; fetch the low byte
                hi_next    = fr_data;
                fr_addr    = fa18[FI_W-1:0] + FI_W'(1);
                state_next = S_W10_C;
            end
            S_W10_C:
            begin
                we     = 1'b1;
                wdata  = {hi_reg, fr_data};
                i_next = i_reg + 16'd1;
                if (i_last)
                    state_next = S_HDR;
                else
                    state_next = S_W10_A;
            end
            S_HDR:
            begin
                if (!out_full)
                begin
                    out_push         = 1'b1;
                    out_data.tx_byte = hdr_byte;
                    crc_next         = crc_byte(crc_reg, hdr_byte);
                    h_next           = h_reg + 3'd1;
                    if (cmd_reg.fn == FN_READ)
                    begin
                        if (h_reg == HDR_LAST_RD)
                        begin
                            i_next     = 16'd0;
                            state_next = S_RD_A;
                        end
                    end
                    else if (h_reg == HDR_LAST_WR)
                        state_next = S_CRC_LO;
                end
            end
            S_RD_A:
            begin
                re         = 1'b1;
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                if (!out_full)
                begin
                    out_push         = 1'b1;
                    out_data.tx_byte = rdata_reg[15:8];
                    crc_next         = crc_byte(crc_reg, rdata_reg[15:8]);
                    state_next       = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                if (!out_full)
                begin
                    out_push         = 1'b1;
                    out_data.tx_byte = rdata_reg[7:0];
                    crc_next         = crc_byte(crc_reg, rdata_reg[7:0]);
                    i_next           = i_reg + 16'd1;
                    if (i_last)
                        state_next = S_CRC_LO;
                    else
                        state_next = S_RD_A;
                end
            end
            S_CRC_LO:
            begin
                if (!out_full)
                begin
                    out_push         = 1'b1;
                    out_data.tx_byte = crc_reg[7:0];
                    state_next       = S_CRC_HI;
                end
            end
            S_CRC_HI:
            begin
                if (!out_full)
                begin
                    out_push              = 1'b1;
                    out_data.tx_byte      = crc_reg[15:8];
                    out_data.tx_last      = 1'b1;
                    out_data.data_changed = (cmd_reg.fn != FN_READ);
                    bk_stat.frame_done    = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            S_LRD_OUT:
            begin
                if (!out_full)
                begin
                    out_push            = 1'b1;
                    out_data.tx_last    = 1'b1;
                    out_data.read_value = oor_reg ? 16'd0 : rdata_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            i_reg     <= 16'd0;
            h_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            i_reg     <= i_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        cmd_reg <= cmd_next;
        hi_reg  <= hi_next;
        oor_reg <= oor_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            rmem[waddr] <= wdata;
        if (re)
            rdata_reg <= rmem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/modbus_rtu_slave_frame_handler.sv @@
// Top level of the Modbus RTU slave frame handler: config registers, queues and both ends.
//
//   channel   | handshake                         | payload
//   ----------+-----------------------------------+------------------------------------------
//   input     | push / full                       | kind, rx_byte, frame_end, local_addr,
//             |                                   | local_value
//   result    | empty / pop                       | tx_byte, tx_last, read_value, data_changed
//   config    | cfg_we (no wait)                  | cfg_index, cfg_data
//
// A frame byte is taken per accepted push; the closing byte is followed by a registered closing
// step that checks CRC and range. Responses leave one byte per cycle for the header and CRC
// while the result queue has room; each register read for function 0x03 passes read, high-byte
// and low-byte states, each register written by 0x10 fetch, high-byte and write states, set
// by the registered register and frame store reads. After reset the store is cleared entry
// by entry while full stays high. Input is held off while a checked frame is still being
// served; results wait in a two-entry queue so pop may stall without losing a transaction.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_slave_frame_handler
    import mrtu_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_end,
    input  wire logic [7:0]  local_addr,
    input  wire logic [15:0] local_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       tx_byte,
    output logic             tx_last,
    output logic [15:0]      read_value,
    output logic             data_changed,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int FI_W = $clog2(FRAME_BYTES);

    logic [7:0]      station_reg;
    logic [15:0]     base_reg;
    logic [8:0]      count_reg;

    logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t            cmd_in, cmd_out;
    logic            out_push, out_full;
    out_t            out_in, out_head;
    bk_stat_t        bk_stat;
    logic [FI_W-1:0] fr_addr;
    logic [7:0]      fr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= 8'd1;
            base_reg    <= 16'd0;
            count_reg   <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STATION: station_reg <= cfg_data[7:0];
                CFG_BASE:    base_reg    <= cfg_data;
                CFG_COUNT:   count_reg   <= cfg_data[8:0];
                default:     ;
            endcase
        end
    end

    mrtu_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .REG_COUNT   (REG_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .frame_end    (frame_end),
        .local_addr   (local_addr),
        .local_value  (local_value),
        .window_base  (base_reg),
        .window_count (count_reg),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_in),
        .cmd_full     (cmd_full),
        .bk_stat      (bk_stat),
        .fr_addr      (fr_addr),
        .fr_data      (fr_data)
    );

    mrtu_fifo #(
        .W ($bits(cmd_t))
    ) u_cmd_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (cmd_push),
        .wdata  (cmd_in),
        .qfull  (cmd_full),
        .rd     (cmd_pop),
        .rdata  (cmd_out),
        .qempty (cmd_empty)
    );

    mrtu_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .REG_COUNT   (REG_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .station_id (station_reg),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .cmd_data   (cmd_out),
        .out_full   (out_full),
        .out_push   (out_push),
        .out_data   (out_in),
        .fr_addr    (fr_addr),
        .fr_data    (fr_data),
        .bk_stat    (bk_stat)
    );

    mrtu_fifo #(
        .W ($bits(out_t))
    ) u_out_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (out_push),
        .wdata  (out_in),
        .qfull  (out_full),
        .rd     (pop),
        .rdata  (out_head),
        .qempty (empty)
    );

    assign tx_byte      = out_head.tx_byte;
    assign tx_last      = out_head.tx_last;
    assign read_value   = out_head.read_value;
    assign data_changed = out_head.data_changed;

    // A write flag only ever rides on the closing byte of a response
    a_changed_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && data_changed) |-> tx_last)
        else $error("data_changed without tx_last");

    // A local read result carries no response byte
    a_read_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (read_value != 16'd0)) |-> (tx_byte == 8'd0))
        else $error("read result with a response byte");

    // Hold input off while the store is being cleared
    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.clearing |-> full)
        else $error("input open during store clear");

    // Frame completion only when the back end pushes a result
    a_done_push: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.frame_done |-> (out_push && !out_full))
        else $error("frame done without a result push");

endmodule

`default_nettype wire
